### rtl/dpws_pkg.sv
// Package for the DCC packet waveform serializer: beat types, phase codes,
// register indexes and reset values. No dependencies.
`default_nettype none

package dpws_pkg;

  // Sizes and reset values
  localparam int unsigned MAX_PACKET_BYTES_DEF = 6;
  localparam int unsigned DATA_W               = 48;
  localparam int unsigned DATA_PAD_W           = 64;
  localparam logic [15:0] ONE_HALF_RST         = 16'd58;
  localparam logic [15:0] ZERO_HALF_RST        = 16'd100;
  localparam logic [4:0]  PREAMBLE_RST         = 5'd14;
  localparam logic [3:0]  BYTE_BITS            = 4'd8;

  // Opcodes of an input beat
  localparam logic OP_OFFER  = 1'b0;
  localparam logic OP_EXPIRY = 1'b1;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_ONE_HALF  = 2'd0;
  localparam logic [1:0] REG_ZERO_HALF = 2'd1;
  localparam logic [1:0] REG_PREAMBLE  = 2'd2;

  // Serializer phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PREAMBLE = 3'd1,
    PH_BSTART   = 3'd2,
    PH_BYTE     = 3'd3,
    PH_END      = 3'd4
  } phase_t;

  // Input beat
  typedef struct packed {
    logic        opcode;
    logic [47:0] packet_data;
    logic [2:0]  packet_length;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic        track_level;
    logic [15:0] half_period;
    logic        packet_accepted;
    logic        packet_pending;
  } out_item_t;

  // Classified beat held in the queue between front and engine
  typedef struct packed {
    logic        opcode;
    logic        offer_ok;
    logic [47:0] data;
    logic [2:0]  len;
  } q_item_t;

  // Handshake from the queue to the engine
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

`default_nettype wire

### rtl/dpws_front.sv
// Front end: takes input beats, clamps the packet length, flags usable offers
// and holds them in a two-entry queue. Depends on dpws_pkg.
`default_nettype none

module dpws_front
  import dpws_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output q_head_t       q_head,
  input  wire logic     q_pop
);

  localparam logic [3:0] MAX_LEN = 4'(MAX_PACKET_BYTES);

  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  q_item_t    q_mem_r [2];
  q_item_t    cls_item;
  logic       push;

  // Classify the incoming beat
  always_comb begin
    cls_item.opcode   = in_item.opcode;
    cls_item.data     = in_item.packet_data;
    cls_item.offer_ok = (in_item.packet_length != 3'd0);
    if ({1'b0, in_item.packet_length} > MAX_LEN) begin
      cls_item.len = MAX_LEN[2:0];
    end else begin
      cls_item.len = in_item.packet_length;
    end
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;

  assign q_head.valid = (count_r != 2'd0);
  assign q_head.item  = q_mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

`default_nettype wire

### rtl/dpws_engine.sv
// Back end: bit sequencer that turns queued beats into track half-periods,
// with the packet store and the result register. Depends on dpws_pkg.
`default_nettype none

module dpws_engine
  import dpws_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire q_head_t     q_head,
  output logic             q_pop,
  input  wire logic [15:0] one_half,
  input  wire logic [15:0] zero_half,
  input  wire logic [4:0]  preamble_len,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item
);

  localparam int unsigned IDX_W   = $clog2(MAX_PACKET_BYTES);
  localparam logic [3:0]  MAX_LEN = 4'(MAX_PACKET_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  stored_len_r, stored_len_nxt;
  logic [2:0]  bytes_left_r, bytes_left_nxt;
  logic [4:0]  bits_left_r, bits_left_nxt;
  logic        level_r, level_nxt;
  logic [15:0] period_r, period_nxt;
  logic [7:0]  packet_r [MAX_PACKET_BYTES];
  logic        out_valid_r;
  out_item_t   out_item_r;

  logic        can_load, rise, take_offer;
  logic [4:0]  bits_dec;
  logic [2:0]  bytes_dec, idx;
  logic [7:0]  byte_sel;
  logic        data_bit;
  logic [DATA_PAD_W-1:0] data_pad;

  assign can_load   = !out_valid_r || !out_stall;
  assign q_pop      = q_head.valid && can_load;
  assign rise       = q_pop && (q_head.item.opcode == OP_EXPIRY) && !level_r;
  assign take_offer = q_pop && (q_head.item.opcode == OP_OFFER) && q_head.item.offer_ok &&
                      (bytes_left_r == 3'd0);

  assign bits_dec  = bits_left_r - 5'd1;
  assign bytes_dec = bytes_left_r - 3'd1;

  // Current data bit: byte picked by position in the packet, MSB first
  assign idx = stored_len_r - bytes_left_r;
  always_comb begin
    if ({1'b0, idx} < MAX_LEN) begin
      byte_sel = packet_r[idx[IDX_W-1:0]];
    end else begin
      byte_sel = 8'h00;
    end
  end
  assign data_bit = byte_sel[bits_dec[2:0]];

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (rise) begin
      case (phase_r)
        PH_IDLE, PH_PREAMBLE: begin
          if (phase_r == PH_PREAMBLE || bytes_left_r != 3'd0) begin
            phase_nxt = (bits_dec == 5'd0) ? PH_BSTART : PH_PREAMBLE;
          end
        end
        PH_BSTART: phase_nxt = PH_BYTE;
        PH_BYTE: begin
          if (bits_dec == 5'd0) begin
            phase_nxt = (bytes_dec == 3'd0) ? PH_END : PH_BSTART;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Counters, level and period
  always_comb begin
    stored_len_nxt = stored_len_r;
    bytes_left_nxt = bytes_left_r;
    bits_left_nxt  = bits_left_r;
    level_nxt      = level_r;
    period_nxt     = period_r;
    if (take_offer) begin
      stored_len_nxt = q_head.item.len;
      bytes_left_nxt = q_head.item.len;
      bits_left_nxt  = preamble_len;
    end
    if (q_pop && q_head.item.opcode == OP_EXPIRY) begin
      level_nxt = ~level_r;
    end
    if (rise) begin
      case (phase_r)
        PH_IDLE, PH_PREAMBLE: begin
          period_nxt = one_half;
          if (phase_r == PH_PREAMBLE || bytes_left_r != 3'd0) begin
            bits_left_nxt = bits_dec;
          end
        end
        PH_BSTART: begin
          period_nxt    = zero_half;
          bits_left_nxt = {1'b0, BYTE_BITS};
        end
        PH_BYTE: begin
          period_nxt    = data_bit ? one_half : zero_half;
          bits_left_nxt = bits_dec;
          if (bits_dec == 5'd0) begin
            bytes_left_nxt = bytes_dec;
          end
        end
        default: begin
          period_nxt    = one_half;
          bits_left_nxt = preamble_len;
        end
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      stored_len_r <= 3'd0;
      bytes_left_r <= 3'd0;
      bits_left_r  <= PREAMBLE_RST;
      level_r      <= 1'b0;
      period_r     <= ZERO_HALF_RST;
    end else begin
      phase_r      <= phase_nxt;
      stored_len_r <= stored_len_nxt;
      bytes_left_r <= bytes_left_nxt;
      bits_left_r  <= bits_left_nxt;
      level_r      <= level_nxt;
      period_r     <= period_nxt;
    end
  end

  // Packet store: first byte at entry 0, entries past the data read as zero
  assign data_pad = {q_head.item.data, {(DATA_PAD_W - DATA_W){1'b0}}};
  always_ff @(posedge clk) begin
    if (take_offer) begin
      for (int k = 0; k < MAX_PACKET_BYTES; k++) begin
        packet_r[k] <= data_pad[DATA_PAD_W-1-8*k -: 8];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item_r.track_level     <= level_nxt;
      out_item_r.half_period     <= period_nxt;
      out_item_r.packet_accepted <= take_offer;
      out_item_r.packet_pending  <= (bytes_left_nxt != 3'd0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

### rtl/dcc_packet_waveform_serializer.sv
// DCC packet waveform serializer, top level. An accepted beat passes the two-entry
// queue and then the result register before its result beat is valid.
// Throughput: one beat per cycle unless output stalls fill the queue; the queue plus
// the result register absorb output stalls. Reset (synchronous, rst_n low): registers
// to defaults, queue and result register empty, track level low, half-period 100.
// Depends on dpws_pkg, dpws_front and dpws_engine.
`default_nettype none

module dcc_packet_waveform_serializer
  import dpws_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [15:0] one_half_r;
  logic [15:0] zero_half_r;
  logic [4:0]  preamble_r;
  logic        cfg_wr;
  q_head_t     q_head;
  logic        q_pop;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_half_r  <= ONE_HALF_RST;
      zero_half_r <= ZERO_HALF_RST;
      preamble_r  <= PREAMBLE_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_ONE_HALF:  one_half_r  <= cfg_pwdata[15:0];
        REG_ZERO_HALF: zero_half_r <= cfg_pwdata[15:0];
        REG_PREAMBLE:  preamble_r  <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_paddr[3:2])
      REG_ONE_HALF:  cfg_prdata = {16'd0, one_half_r};
      REG_ZERO_HALF: cfg_prdata = {16'd0, zero_half_r};
      REG_PREAMBLE:  cfg_prdata = {27'd0, preamble_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  dpws_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  dpws_engine #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .one_half     (one_half_r),
    .zero_half    (zero_half_r),
    .preamble_len (preamble_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item)
  );

endmodule

`default_nettype wire

### rtl/dpws_checker.sv
// Port-level checks for the DCC packet waveform serializer, bound to the top
// level. Depends on dpws_pkg.
`default_nettype none

module dpws_checker
  import dpws_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  logic [2:0] outstanding_r;
  logic       last_pending_r;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  // Beats in flight and pending flag of the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r  <= 3'd0;
      last_pending_r <= 1'b0;
    end else begin
      outstanding_r <= outstanding_r + 3'(in_beat) - 3'(out_beat);
      if (out_beat) begin
        last_pending_r <= out_item.packet_pending;
      end
    end
  end

  // No result without an accepted beat behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> outstanding_r != 3'd0)
    else $error("result beat with no input beat in flight");

  // At most queue depth plus result register in flight
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r <= 3'd3)
    else $error("too many beats in flight");

  // A packet is only taken when none is pending, and then it is pending
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.packet_accepted) |->
      (!last_pending_r && out_item.packet_pending))
    else $error("packet taken while another was pending");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result beat changed");

endmodule

bind dcc_packet_waveform_serializer dpws_checker u_dpws_checker (.*);

`default_nettype wire

### test/dpws_track_checker.sv
// Checker for the DCC packet waveform serializer: tracks config writes, predicts
// each result beat from the accepted input beats and compares them in order.
// Depends on dpws_pkg.

module dpws_track_checker
  import dpws_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          mismatch_count,
  output int          beats_in_flight
);

  localparam int unsigned PKT_BYTES = MAX_PACKET_BYTES_DEF;

  // Register copies
  logic [15:0] one_hp;
  logic [15:0] zero_hp;
  logic [4:0]  preamble_len;

  // Serializer state copy
  phase_t      ser_phase;
  logic [7:0]  pkt_bytes [PKT_BYTES];
  logic [2:0]  pkt_len;
  logic [2:0]  bytes_left;
  logic [4:0]  bits_left;
  logic        level;
  logic [15:0] cur_period;

  out_item_t   track_expect_q [$];

  // Rising track level: choose the half-period of the bit that starts now
  function automatic void start_next_bit();
    logic [2:0] idx;
    logic [7:0] cur_byte;
    logic [2:0] sh;
    if (ser_phase == PH_IDLE || ser_phase > PH_END) begin
      if (bytes_left == 3'd0) begin
        cur_period = one_hp;
        return;
      end
      ser_phase = PH_PREAMBLE;
    end
    case (ser_phase)
      PH_PREAMBLE: begin
        cur_period = one_hp;
        bits_left  = bits_left - 5'd1;   // zero preamble wraps around here
        if (bits_left == 5'd0) ser_phase = PH_BSTART;
      end
      PH_BSTART: begin
        cur_period = zero_hp;
        ser_phase  = PH_BYTE;
        bits_left  = {1'b0, BYTE_BITS};
      end
      PH_BYTE: begin
        idx        = pkt_len - bytes_left;
        cur_byte   = (idx < PKT_BYTES) ? pkt_bytes[idx] : 8'h00;
        sh         = bits_left[2:0] - 3'd1;
        cur_period = cur_byte[sh] ? one_hp : zero_hp;
        bits_left  = bits_left - 5'd1;
        if (bits_left == 5'd0) begin
          bytes_left = bytes_left - 3'd1;
          ser_phase  = (bytes_left == 3'd0) ? PH_END : PH_BSTART;
        end
      end
      default: begin
        // closing one bit, then back to idle
        cur_period = one_hp;
        ser_phase  = PH_IDLE;
        bits_left  = preamble_len;
      end
    endcase
  endfunction

  // One input beat in, one result beat out
  function automatic out_item_t serialize_step(in_item_t beat);
    out_item_t  res;
    logic       taken;
    logic [2:0] len;
    taken = 1'b0;
    if (beat.opcode == OP_OFFER) begin
      len = beat.packet_length;
      if (bytes_left == 3'd0 && len != 3'd0) begin
        if (len > PKT_BYTES) len = 3'(PKT_BYTES);
        for (int k = 0; k < PKT_BYTES; k++) begin
          pkt_bytes[k] = (k < 6) ? beat.packet_data[47 - 8 * k -: 8] : 8'h00;
        end
        pkt_len    = len;
        bytes_left = len;
        bits_left  = preamble_len;
        taken      = 1'b1;
      end
    end else begin
      level = ~level;
      if (level) start_next_bit();
    end
    res.track_level     = level;
    res.half_period     = cur_period;
    res.packet_accepted = taken;
    res.packet_pending  = (bytes_left != 3'd0);
    return res;
  endfunction

  // Watch all three ports at each edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      one_hp       = ONE_HALF_RST;
      zero_hp      = ZERO_HALF_RST;
      preamble_len = PREAMBLE_RST;
      ser_phase    = PH_IDLE;
      for (int k = 0; k < PKT_BYTES; k++) pkt_bytes[k] = 8'h00;
      pkt_len      = 3'd0;
      bytes_left   = 3'd0;
      bits_left    = PREAMBLE_RST;
      level        = 1'b0;
      cur_period   = ZERO_HALF_RST;
      track_expect_q.delete();
      mismatch_count = 0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (track_expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result beat: level=%0d period=%0d acc=%0d pend=%0d",
                     out_item.track_level, out_item.half_period,
                     out_item.packet_accepted, out_item.packet_pending);
        end else begin
          want = track_expect_q.pop_front();
          if (out_item.track_level !== want.track_level ||
              out_item.half_period !== want.half_period ||
              out_item.packet_accepted !== want.packet_accepted ||
              out_item.packet_pending !== want.packet_pending) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result mismatch: exp level=%0d period=%0d acc=%0d pend=%0d,",
                        " got level=%0d period=%0d acc=%0d pend=%0d"},
                       want.track_level, want.half_period,
                       want.packet_accepted, want.packet_pending,
                       out_item.track_level, out_item.half_period,
                       out_item.packet_accepted, out_item.packet_pending);
          end
        end
      end
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_ONE_HALF:  one_hp       = cfg_pwdata[15:0];
          REG_ZERO_HALF: zero_hp      = cfg_pwdata[15:0];
          REG_PREAMBLE:  preamble_len = cfg_pwdata[4:0];
          default: ;
        endcase
      end
      // input beat
      if (in_valid && !in_stall) track_expect_q.push_back(serialize_step(in_item));
    end
    beats_in_flight = track_expect_q.size();
  end

endmodule

### test/dcc_packet_waveform_serializer_tb.sv
// Testbench top for the DCC packet waveform serializer: clock, reset, register
// writes, packet and timer-expiry stimulus, random stalls and the verdict.
// Depends on dpws_pkg, dcc_packet_waveform_serializer and dpws_track_checker.

module dcc_packet_waveform_serializer_tb;
  import dpws_pkg::*;

  localparam int CYCLE_LIMIT = 150000;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_item_t    in_item     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_item_t   out_item;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          mismatch_count;
  int          beats_in_flight;
  int          cycle_count    = 0;
  int          sender_gap_pct = 0;
  int          recv_stall_pct = 0;
  logic [4:0]  preamble_cfg   = PREAMBLE_RST;

  dcc_packet_waveform_serializer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  dpws_track_checker track_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .mismatch_count  (mismatch_count),
    .beats_in_flight (beats_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[dcc_packet_waveform_serializer] ERROR");
      $finish;
    end
  end

  function automatic logic [47:0] rand_data();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  // Write all three registers; setup then access phase for each
  task automatic write_config(input logic [15:0] one_hp, input logic [15:0] zero_hp,
                              input logic [4:0] pre_len);
    logic [1:0]  reg_idx [3];
    logic [31:0] reg_val [3];
    logic        rdy;
    reg_idx = '{REG_ONE_HALF, REG_ZERO_HALF, REG_PREAMBLE};
    reg_val = '{{16'h0, one_hp}, {16'h0, zero_hp}, {27'h0, pre_len}};
    for (int i = 0; i < 3; i++) begin
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b1;
      cfg_paddr   <= {reg_idx[i], 2'b00};
      cfg_pwdata  <= reg_val[i];
      @(posedge clk);
      cfg_penable <= 1'b1;
      do begin
        @(negedge clk);
        rdy = cfg_pready;
        @(posedge clk);
      end while (!rdy);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    preamble_cfg = pre_len;
  endtask

  // Offer one beat, with random gaps ahead of it; returns on the accepting edge
  task automatic send_beat(input in_item_t beat);
    logic stalled;
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= beat;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic send_offer(input logic [47:0] data, input logic [2:0] len);
    in_item_t beat;
    beat.opcode        = OP_OFFER;
    beat.packet_data   = data;
    beat.packet_length = len;
    send_beat(beat);
  endtask

  // Timer expiry; the unused fields carry random bits
  task automatic send_expiry();
    in_item_t beat;
    beat.opcode        = OP_EXPIRY;
    beat.packet_data   = rand_data();
    beat.packet_length = 3'($urandom_range(7));
    send_beat(beat);
  endtask

  // Hold the sender until every predicted beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (beats_in_flight == 0);
    @(posedge clk);
  endtask

  // Mostly whole packets followed by enough expiries to clock them out,
  // some cut short, plus short bursts of noise
  task automatic run_traffic(input int budget);
    int         taken;
    int         pick;
    int         pre_ones;
    int         n_exp;
    logic [2:0] len;
    in_item_t   beat;
    taken = 0;
    while (taken < budget) begin
      if ($urandom_range(99) < 70) begin
        pick = $urandom_range(99);
        if (pick < 70) len = 3'($urandom_range(1, 2));
        else if (pick < 92) len = 3'($urandom_range(3, 6));
        else len = 3'd7;
        send_offer(rand_data(), len);
        taken++;
        pre_ones = (preamble_cfg == 5'd0) ? 32 : int'(preamble_cfg);
        n_exp = 2 * (pre_ones + 9 * ((len > 6) ? 6 : int'(len)) + 1) +
                int'($urandom_range(0, 4));
        if ($urandom_range(99) < 15) n_exp = $urandom_range(1, n_exp);
        // stay within the beat budget; a packet left running carries over
        if (n_exp > budget - taken) n_exp = budget - taken;
        repeat (n_exp) begin
          send_expiry();
          taken++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          beat.opcode        = 1'($urandom_range(1));
          beat.packet_data   = rand_data();
          beat.packet_length = 3'($urandom_range(7));
          send_beat(beat);
          if (beat.opcode == OP_EXPIRY) taken++;
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle ones at reset periods, zero-length offer
    send_expiry();
    send_expiry();
    send_offer(48'h0, 3'd0);
    drain_results();

    // Directed: extreme periods, one-bit preamble, all-ones byte, offer while busy
    write_config(16'd1, 16'hFFFF, 5'd1);
    send_offer(48'hFF00_0000_0000, 3'd1);
    send_offer(48'hFFFF_FFFF_FFFF, 3'd6);
    repeat (22) send_expiry();
    drain_results();

    // Sender idles lightly, receiver heavily
    sender_gap_pct = 34;
    recv_stall_pct = 79;
    write_config(16'hFFFF, 16'd1, 5'd1);
    run_traffic(88);
    drain_results();
    write_config(16'($urandom_range(1, 16'hFFFF)), 16'($urandom_range(1, 16'hFFFF)), 5'd3);
    run_traffic(88);
    drain_results();

    // Sender idles heavily, receiver lightly; zero preamble wraps
    sender_gap_pct = 79;
    recv_stall_pct = 34;
    write_config(16'd1, 16'hFFFF, 5'd0);
    run_traffic(88);
    drain_results();
    write_config(16'($urandom_range(1, 16'hFFFF)), 16'($urandom_range(1, 16'hFFFF)), 5'd31);
    run_traffic(88);
    drain_results();

    // Full rate both ways
    sender_gap_pct = 0;
    recv_stall_pct = 0;
    write_config(16'($urandom_range(1, 16'hFFFF)), 16'($urandom_range(1, 16'hFFFF)),
                 5'($urandom_range(1, 4)));
    run_traffic(88);
    drain_results();
    write_config(ONE_HALF_RST, ZERO_HALF_RST, 5'd2);
    run_traffic(88);
    drain_results();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[dcc_packet_waveform_serializer] OK");
    end else begin
      $display("[dcc_packet_waveform_serializer] ERROR");
    end
    $finish;
  end

endmodule
